>>> rtl/fohm_pkg.sv
// shared types, constants and codes for the offset histogram matcher
`timescale 1ns / 1ps
package fohm_pkg;

    localparam int HASH_W  = 32;
    localparam int TIME_W  = 20;
    localparam int DELTA_W = 21;
    localparam int CNT_W   = 20;
    localparam int CONF_W  = 32;
    localparam int FUNC_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // dividend is best count shifted by the 16 fraction bits
    localparam int FRAC_W   = 16;
    localparam int DIVD_W   = CNT_W + FRAC_W;
    localparam int DIVC_W   = $clog2(DIVD_W + 1);

    localparam int QUERY_DEPTH_DEF = 1024;
    localparam int DELTA_DEPTH_DEF = 1024;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [HASH_W-1:0] hash;
        logic [TIME_W-1:0] anchor_time;
    } t_in_beat;

    typedef struct packed {
        logic [CONF_W-1:0] confidence;
        logic [CNT_W-1:0]  best_count;
        logic [CNT_W-1:0]  query_total;
        logic              query_overflow;
        logic              delta_overflow;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_Q_RD,
        S_Q_CMP,
        S_D_RD,
        S_D_CMP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic q_rd;
        logic q_ins;
        logic q_ovf;
        logic q_upd;
        logic q_next;
        logic d_start;
        logic d_rd;
        logic d_ins;
        logic d_ovf;
        logic d_upd;
        logic d_next;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              q_end;
        logic              q_full;
        logic              q_hit;
        logic              d_end;
        logic              d_full;
        logic              d_hit;
        logic              div_done;
        logic              out_busy;
    } t_status;

endpackage

>>> rtl/fingerprint_offset_histogram_match.sv
// Fingerprint time-offset histogram matcher, top level.
// Input beats (i_valid/o_stall) carry func, hash and anchor time. A load beat
// stores a query hash and time, a probe beat looks the hash up and counts the
// time delta of a hit, a report beat produces one output beat and clears.
// Output beats (o_valid/i_stall) carry confidence (Q16.16), best count, query
// total and the two sticky overflow flags; only report beats produce one.
// One beat is worked on at a time; o_stall is high while it is busy.
// Tables are scanned in fill order, one ram read and one compare per entry.
// A load scans the query table; a probe scans it too and, on a hit, also
// scans the delta table. A report runs 36 divider steps, a done state and
// an output state before o_valid rises. A load or probe lasts as long as its
// serial scan through the table ram.
// A waiting result sits in the output register and does not block loads or
// probes; a report waits in its last state while the previous result is
// stalled. Reset empties both tables (fill counts), clears counters and
// flags and drops any pending output; no clearing pass is needed.
`timescale 1ns / 1ps
module fingerprint_offset_histogram_match #(
    parameter int QUERY_DEPTH = fohm_pkg::QUERY_DEPTH_DEF,
    parameter int DELTA_DEPTH = fohm_pkg::DELTA_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fohm_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output fohm_pkg::t_out_beat o_data
);

    fohm_pkg::t_cmd    cmd;
    fohm_pkg::t_status st;

    fohm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_data.func),
        .i_st    (st),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    fohm_dp #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .DELTA_DEPTH (DELTA_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_stall (i_stall),
        .i_cmd   (cmd),
        .o_st    (st),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

>>> rtl/fohm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fohm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fohm_ctrl.sv
// sequencer for table scans, division and result hand-off
`timescale 1ns / 1ps
module fohm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_func,
    input  fohm_pkg::t_status i_st,
    output logic            o_stall,
    output fohm_pkg::t_cmd  o_cmd
);

    fohm_pkg::t_state r_state;
    fohm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fohm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fohm_pkg::S_IDLE: begin
                if (i_valid) begin
                    priority if (i_func == fohm_pkg::FUNC_LOAD ||
                                 i_func == fohm_pkg::FUNC_PROBE) begin
                        n_state = fohm_pkg::S_Q_RD;
                    end else if (i_func == fohm_pkg::FUNC_REPORT) begin
                        n_state = fohm_pkg::S_DIV;
                    end else begin
                        n_state = fohm_pkg::S_IDLE;
                    end
                end
            end
            fohm_pkg::S_Q_RD: begin
                n_state = i_st.q_end ? fohm_pkg::S_IDLE : fohm_pkg::S_Q_CMP;
            end
            fohm_pkg::S_Q_CMP: begin
                priority if (!i_st.q_hit) begin
                    n_state = fohm_pkg::S_Q_RD;
                end else if (i_st.func == fohm_pkg::FUNC_PROBE) begin
                    n_state = fohm_pkg::S_D_RD;
                end else begin
                    n_state = fohm_pkg::S_IDLE;
                end
            end
            fohm_pkg::S_D_RD: begin
                n_state = i_st.d_end ? fohm_pkg::S_IDLE : fohm_pkg::S_D_CMP;
            end
            fohm_pkg::S_D_CMP: begin
                n_state = i_st.d_hit ? fohm_pkg::S_IDLE : fohm_pkg::S_D_RD;
            end
            fohm_pkg::S_DIV: begin
                if (i_st.div_done) begin
                    n_state = fohm_pkg::S_OUT;
                end
            end
            fohm_pkg::S_OUT: begin
                if (!i_st.out_busy) begin
                    n_state = fohm_pkg::S_IDLE;
                end
            end
            default: n_state = fohm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != fohm_pkg::S_IDLE);
        unique case (r_state)
            fohm_pkg::S_IDLE: begin
                o_cmd.accept = i_valid;
            end
            fohm_pkg::S_Q_RD: begin
                if (i_st.q_end) begin
                    if (i_st.func == fohm_pkg::FUNC_LOAD) begin
                        o_cmd.q_ovf = i_st.q_full;
                        o_cmd.q_ins = !i_st.q_full;
                    end
                end else begin
                    o_cmd.q_rd = 1'b1;
                end
            end
            fohm_pkg::S_Q_CMP: begin
                priority if (!i_st.q_hit) begin
                    o_cmd.q_next = 1'b1;
                end else if (i_st.func == fohm_pkg::FUNC_PROBE) begin
                    o_cmd.d_start = 1'b1;
                end else begin
                    o_cmd.q_upd = 1'b1;
                end
            end
            fohm_pkg::S_D_RD: begin
                if (i_st.d_end) begin
                    o_cmd.d_ovf = i_st.d_full;
                    o_cmd.d_ins = !i_st.d_full;
                end else begin
                    o_cmd.d_rd = 1'b1;
                end
            end
            fohm_pkg::S_D_CMP: begin
                o_cmd.d_upd  = i_st.d_hit;
                o_cmd.d_next = !i_st.d_hit;
            end
            fohm_pkg::S_DIV: begin
                o_cmd.div_step = !i_st.div_done;
            end
            fohm_pkg::S_OUT: begin
                o_cmd.out_load = !i_st.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/fohm_dp.sv
// datapath: query and delta tables, counters, divider, output register
`timescale 1ns / 1ps
module fohm_dp #(
    parameter int QUERY_DEPTH = fohm_pkg::QUERY_DEPTH_DEF,
    parameter int DELTA_DEPTH = fohm_pkg::DELTA_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fohm_pkg::t_in_beat i_data,
    input  logic               i_stall,
    input  fohm_pkg::t_cmd     i_cmd,
    output fohm_pkg::t_status  o_st,
    output logic               o_valid,
    output fohm_pkg::t_out_beat o_data
);

    localparam int QA_W = $clog2(QUERY_DEPTH);
    localparam int QF_W = $clog2(QUERY_DEPTH + 1);
    localparam int DA_W = $clog2(DELTA_DEPTH);
    localparam int DF_W = $clog2(DELTA_DEPTH + 1);
    localparam int QW_W = fohm_pkg::HASH_W + fohm_pkg::TIME_W;
    localparam int DW_W = fohm_pkg::DELTA_W + fohm_pkg::CNT_W;
    localparam logic [QF_W-1:0] Q_FULL = QF_W'(QUERY_DEPTH);
    localparam logic [DF_W-1:0] D_FULL = DF_W'(DELTA_DEPTH);
    localparam int CW = fohm_pkg::CNT_W;

    // item registers
    logic [fohm_pkg::FUNC_W-1:0]  r_func;
    logic [fohm_pkg::HASH_W-1:0]  r_hash;
    logic [fohm_pkg::TIME_W-1:0]  r_time;
    logic [fohm_pkg::DELTA_W-1:0] r_delta;

    logic [QF_W-1:0] r_qfill;
    logic [QF_W-1:0] r_qidx;
    logic [DF_W-1:0] r_dfill;
    logic [DF_W-1:0] r_didx;
    logic [CW-1:0]   r_load;
    logic [CW-1:0]   r_top;
    logic            r_qovf;
    logic            r_dovf;

    logic [CW-1:0]                r_rem;
    logic [fohm_pkg::DIVD_W-1:0]  r_quo;
    logic [fohm_pkg::DIVC_W-1:0]  r_dcnt;

    logic                r_ov;
    fohm_pkg::t_out_beat r_out;

    // table ports
    logic            q_we;
    logic [QA_W-1:0] q_waddr;
    logic [QW_W-1:0] q_wdata;
    logic [QW_W-1:0] q_rdata;
    logic            d_we;
    logic [DA_W-1:0] d_waddr;
    logic [DW_W-1:0] d_wdata;
    logic [DW_W-1:0] d_rdata;

    logic [fohm_pkg::HASH_W-1:0]  q_rkey;
    logic [fohm_pkg::TIME_W-1:0]  q_rtime;
    logic [fohm_pkg::DELTA_W-1:0] d_rkey;
    logic [CW-1:0]                d_rcnt;
    logic [CW-1:0]                d_inc;
    logic [CW:0]                  div_trial;
    logic [CW:0]                  div_shift;
    logic [fohm_pkg::CONF_W-1:0]  conf;

    assign q_rkey  = q_rdata[QW_W-1 -: fohm_pkg::HASH_W];
    assign q_rtime = q_rdata[fohm_pkg::TIME_W-1:0];
    assign d_rkey  = d_rdata[DW_W-1 -: fohm_pkg::DELTA_W];
    assign d_rcnt  = d_rdata[CW-1:0];
    assign d_inc   = (d_rcnt == fohm_pkg::CNT_MAX) ? d_rcnt : d_rcnt + 1'b1;

    assign q_we    = i_cmd.q_ins | i_cmd.q_upd;
    assign q_waddr = i_cmd.q_ins ? r_qfill[QA_W-1:0] : r_qidx[QA_W-1:0];
    assign q_wdata = {r_hash, r_time};
    assign d_we    = i_cmd.d_ins | i_cmd.d_upd;
    assign d_waddr = i_cmd.d_ins ? r_dfill[DA_W-1:0] : r_didx[DA_W-1:0];
    assign d_wdata = i_cmd.d_ins ? {r_delta, CW'(1)} : {r_delta, d_inc};

    fohm_ram #(.WIDTH(QW_W), .DEPTH(QUERY_DEPTH)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (i_cmd.q_rd),
        .i_raddr (r_qidx[QA_W-1:0]),
        .o_rdata (q_rdata)
    );

    fohm_ram #(.WIDTH(DW_W), .DEPTH(DELTA_DEPTH)) u_dram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (i_cmd.d_rd),
        .i_raddr (r_didx[DA_W-1:0]),
        .o_rdata (d_rdata)
    );

    // restoring divider, one quotient bit per cycle
    assign div_shift = {r_rem, r_quo[fohm_pkg::DIVD_W-1]};
    assign div_trial = div_shift - {1'b0, r_load};

    always_comb begin
        if (r_load == '0) begin
            conf = '0;
        end else if (r_quo[fohm_pkg::DIVD_W-1:fohm_pkg::CONF_W] != '0) begin
            conf = '1;
        end else begin
            conf = r_quo[fohm_pkg::CONF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_data.func;
            r_hash <= i_data.hash;
            r_time <= i_data.anchor_time;
            r_rem  <= '0;
            r_quo  <= {r_top, {fohm_pkg::FRAC_W{1'b0}}};
        end
        if (i_cmd.d_start) begin
            r_delta <= {1'b0, r_time} - {1'b0, q_rtime};
        end
        if (i_cmd.div_step) begin
            if (!div_trial[CW]) begin
                r_rem <= div_trial[CW-1:0];
                r_quo <= {r_quo[fohm_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= div_shift[CW-1:0];
                r_quo <= {r_quo[fohm_pkg::DIVD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out.confidence     <= conf;
            r_out.best_count     <= r_top;
            r_out.query_total    <= r_load;
            r_out.query_overflow <= r_qovf;
            r_out.delta_overflow <= r_dovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qfill <= '0;
            r_dfill <= '0;
            r_qidx  <= '0;
            r_didx  <= '0;
            r_load  <= '0;
            r_top   <= '0;
            r_qovf  <= 1'b0;
            r_dovf  <= 1'b0;
            r_dcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_qidx <= '0;
                r_dcnt <= fohm_pkg::DIVC_W'(fohm_pkg::DIVD_W);
                if (i_data.func == fohm_pkg::FUNC_LOAD && r_load != fohm_pkg::CNT_MAX) begin
                    r_load <= r_load + 1'b1;
                end
            end
            if (i_cmd.q_next) begin
                r_qidx <= r_qidx + 1'b1;
            end
            if (i_cmd.q_ins) begin
                r_qfill <= r_qfill + 1'b1;
            end
            if (i_cmd.q_ovf) begin
                r_qovf <= 1'b1;
            end
            if (i_cmd.d_start) begin
                r_didx <= '0;
            end
            if (i_cmd.d_next) begin
                r_didx <= r_didx + 1'b1;
            end
            if (i_cmd.d_ins) begin
                r_dfill <= r_dfill + 1'b1;
                if (r_top == '0) begin
                    r_top <= CW'(1);
                end
            end
            if (i_cmd.d_upd && d_inc > r_top) begin
                r_top <= d_inc;
            end
            if (i_cmd.d_ovf) begin
                r_dovf <= 1'b1;
            end
            if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
            if (r_ov && !i_stall && !i_cmd.out_load) begin
                r_ov <= 1'b0;
            end
            // report hands the result over and starts a fresh match
            if (i_cmd.out_load) begin
                r_ov    <= 1'b1;
                r_qfill <= '0;
                r_dfill <= '0;
                r_load  <= '0;
                r_top   <= '0;
                r_qovf  <= 1'b0;
                r_dovf  <= 1'b0;
            end
        end
    end

    assign o_st.func     = r_func;
    assign o_st.q_end    = (r_qidx == r_qfill);
    assign o_st.q_full   = (r_qfill == Q_FULL);
    assign o_st.q_hit    = (q_rkey == r_hash);
    assign o_st.d_end    = (r_didx == r_dfill);
    assign o_st.d_full   = (r_dfill == D_FULL);
    assign o_st.d_hit    = (d_rkey == r_delta);
    assign o_st.div_done = (r_dcnt == '0);
    assign o_st.out_busy = r_ov & i_stall;

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

>>> test/fingerprint_offset_histogram_match_tb.sv
// testbench for the fingerprint time-offset histogram matcher
`timescale 1ns / 1ps
module fingerprint_offset_histogram_match_tb;

    localparam int QDEPTH = 1024;
    localparam int DDEPTH = 1024;
    localparam int TW = fohm_pkg::TIME_W;
    localparam int HOLD_LEN = 3000;
    localparam longint CYCLE_LIMIT = 40_000_000;
    // func code with no meaning, must be ignored
    localparam logic [fohm_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    fohm_pkg::t_in_beat  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    fohm_pkg::t_out_beat o_data;

    fingerprint_offset_histogram_match #(
        .QUERY_DEPTH(QDEPTH),
        .DELTA_DEPTH(DDEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    // matcher state as seen by the predictor
    logic [fohm_pkg::TIME_W-1:0] query_time_of[logic [fohm_pkg::HASH_W-1:0]];
    logic [fohm_pkg::CNT_W-1:0]  delta_hits[logic [fohm_pkg::DELTA_W-1:0]];
    logic [fohm_pkg::CNT_W-1:0]  load_tally;
    logic [fohm_pkg::CNT_W-1:0]  top_hits;
    logic                        query_dropped;
    logic                        delta_dropped;

    fohm_pkg::t_out_beat pending_reports[$];
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_reqs = 0;
    int        hold_taken = 0;
    int        hold_left = 0;
    longint    cycle_count = 0;

    typedef struct {
        fohm_pkg::t_in_beat  beat;
        bit                  typed;
        fohm_pkg::t_out_beat want;
    } t_row;
    t_row directed[$];

    logic [fohm_pkg::HASH_W-1:0] hash_pool[16];

    function automatic void clear_matcher();
        query_time_of.delete();
        delta_hits.delete();
        load_tally = '0;
        top_hits = '0;
        query_dropped = 1'b0;
        delta_dropped = 1'b0;
    endfunction

    // returns 1 when the beat produces a report
    function automatic bit predict_match(input fohm_pkg::t_in_beat b,
                                         output fohm_pkg::t_out_beat r);
        logic [fohm_pkg::DELTA_W-1:0] d;
        logic [63:0]                  q;
        r = '0;
        case (b.func)
            fohm_pkg::FUNC_LOAD: begin
                if (load_tally != fohm_pkg::CNT_MAX) load_tally++;
                if (query_time_of.exists(b.hash)) query_time_of[b.hash] = b.anchor_time;
                else if (query_time_of.num() >= QDEPTH) query_dropped = 1'b1;
                else query_time_of[b.hash] = b.anchor_time;
            end
            fohm_pkg::FUNC_PROBE: begin
                if (query_time_of.exists(b.hash)) begin
                    // delta kept as 21-bit two's complement
                    d = {1'b0, b.anchor_time} - {1'b0, query_time_of[b.hash]};
                    if (delta_hits.exists(d)) begin
                        if (delta_hits[d] != fohm_pkg::CNT_MAX) delta_hits[d]++;
                        if (delta_hits[d] > top_hits) top_hits = delta_hits[d];
                    end else if (delta_hits.num() >= DDEPTH) begin
                        delta_dropped = 1'b1;
                    end else begin
                        delta_hits[d] = 1;
                        if (top_hits == 0) top_hits = 1;
                    end
                end
            end
            fohm_pkg::FUNC_REPORT: begin
                q = 0;
                if (load_tally != 0) begin
                    q = {28'd0, top_hits, 16'd0} / {44'd0, load_tally};
                    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
                end
                r.confidence = q[31:0];
                r.best_count = top_hits;
                r.query_total = load_tally;
                r.query_overflow = query_dropped;
                r.delta_overflow = delta_dropped;
                clear_matcher();
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic send_beat(input fohm_pkg::t_in_beat b, input bit typed,
                             input fohm_pkg::t_out_beat want);
        fohm_pkg::t_out_beat r;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_match(b, r))
            pending_reports.insert(pending_reports.size(), typed ? want : r);
    endtask

    task automatic send(input fohm_pkg::t_in_beat b);
        send_beat(b, 1'b0, '0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic fohm_pkg::t_in_beat mk(logic [fohm_pkg::FUNC_W-1:0] f,
                                              logic [fohm_pkg::HASH_W-1:0] h,
                                              logic [TW-1:0] t);
        fohm_pkg::t_in_beat b;
        b.func = f;
        b.hash = h;
        b.anchor_time = t;
        return b;
    endfunction

    function automatic fohm_pkg::t_in_beat random_beat();
        int k;
        logic [fohm_pkg::FUNC_W-1:0] f;
        k = $urandom_range(99);
        if (k < 45) f = fohm_pkg::FUNC_LOAD;
        else if (k < 90) f = fohm_pkg::FUNC_PROBE;
        else if (k < 97) f = fohm_pkg::FUNC_REPORT;
        else f = FUNC_SPARE;
        // mostly a small hash pool and near times so hits and shared deltas happen
        if ($urandom_range(9) == 0)
            return mk(f, $urandom, TW'($urandom_range(20'hFFFFF)));
        return mk(f, hash_pool[$urandom_range(15)],
                  ($urandom_range(3) == 0) ? TW'($urandom_range(20'hFFFFF))
                                           : TW'($urandom_range(40)));
    endfunction

    task automatic add_row(input fohm_pkg::t_in_beat b, input bit typed,
                           input fohm_pkg::t_out_beat want);
        t_row r;
        r.beat = b;
        r.typed = typed;
        r.want = want;
        directed.insert(directed.size(), r);
    endtask

    // receiver side: random stall, or a long hold counted here
    always @(posedge i_clk) begin
        if (hold_reqs != hold_taken) begin
            hold_taken <= hold_reqs;
            hold_left <= HOLD_LEN;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        fohm_pkg::t_out_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report beat %h", $time, o_data);
                errors++;
            end else begin
                e = pending_reports.pop_front();
                if (o_data.confidence !== e.confidence) begin
                    $display("%0t: confidence exp %h got %h", $time, e.confidence,
                             o_data.confidence);
                    errors++;
                end
                if (o_data.best_count !== e.best_count) begin
                    $display("%0t: best_count exp %h got %h", $time, e.best_count,
                             o_data.best_count);
                    errors++;
                end
                if (o_data.query_total !== e.query_total) begin
                    $display("%0t: query_total exp %h got %h", $time, e.query_total,
                             o_data.query_total);
                    errors++;
                end
                if (o_data.query_overflow !== e.query_overflow) begin
                    $display("%0t: query_overflow exp %b got %b", $time, e.query_overflow,
                             o_data.query_overflow);
                    errors++;
                end
                if (o_data.delta_overflow !== e.delta_overflow) begin
                    $display("%0t: delta_overflow exp %b got %b", $time, e.delta_overflow,
                             o_data.delta_overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        fohm_pkg::t_out_beat z;
        z = '0;
        clear_matcher();
        foreach (hash_pool[i]) hash_pool[i] = $urandom;
        hash_pool[0] = 32'h0000_0000;
        hash_pool[1] = 32'hFFFF_FFFF;

        // report right after reset is all zero
        add_row(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0), 1'b1, z);
        add_row(mk(fohm_pkg::FUNC_LOAD, 32'h0000_0000, 20'h00000), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0, z);
        // repeated hash overwrites the stored time
        add_row(mk(fohm_pkg::FUNC_LOAD, 32'h0000_0000, 20'hFFFFF), 1'b0, z);
        // most negative delta, then a zero delta hit twice
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'h0000_0000, 20'h00000), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_LOAD, 32'hA5A5_5A5A, 20'h00010), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'hA5A5_5A5A, 20'hFFFFF), 1'b0, z);
        // probe miss, then unused func ignored
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'h1234_5678, 20'h00001), 1'b0, z);
        add_row(mk(FUNC_SPARE, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_REPORT, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0, z);
        // state cleared by the report
        add_row(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0), 1'b1, z);
        // hits with nothing loaded since clear only come from probes: none
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'hFFFF_FFFF, 20'h0), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_LOAD, 32'h5555_AAAA, 20'h55555), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'h5555_AAAA, 20'hAAAAA), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'h5555_AAAA, 20'hAAAAA), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_PROBE, 32'h5555_AAAA, 20'hAAAAA), 1'b0, z);
        add_row(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0), 1'b0, z);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].want);
        drain();

        // query table full: one more distinct hash is dropped
        for (int i = 0; i <= QDEPTH; i++)
            send(mk(fohm_pkg::FUNC_LOAD, 32'h1000_0000 + 32'(i), TW'(i)));
        send(mk(fohm_pkg::FUNC_PROBE, 32'h1000_0005, 20'd9));
        send(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0));
        drain();

        // delta table full: one more distinct delta is dropped
        send(mk(fohm_pkg::FUNC_LOAD, 32'hCAFE_0001, 20'd0));
        for (int i = 0; i <= DDEPTH; i++)
            send(mk(fohm_pkg::FUNC_PROBE, 32'hCAFE_0001, TW'(i)));
        send(mk(fohm_pkg::FUNC_PROBE, 32'hCAFE_0001, 20'd3));
        send(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 18 : 48) : 0;
            stall_pct = (phase == 2) ? 48 : ((phase == 3) ? 18 : 0);
            if (phase == 0) begin
                // long hold with two reports queued so the input backs up
                hold_reqs++;
                send(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0));
                send(mk(fohm_pkg::FUNC_REPORT, 32'h0, 20'h0));
            end
            for (int n = 0; n < 100; n++) begin
                send(random_beat());
                // in phase 1, halfway through, the sender pauses until every report is back
                if (phase == 1 && n == 50) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_reports.size() != 0) @(posedge i_clk);
                end
            end
            send(mk(fohm_pkg::FUNC_REPORT, $urandom, TW'($urandom_range(20'hFFFFF))));
        end
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
